FILE: sv/ert_pkg.sv
`timescale 1ns / 1ps

package ert_pkg;

  // Number format
  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 32;
  localparam int RHO_BITS  = FRAC_BITS + 2;
  // Multiplier operand width covers both words and rho
  localparam int MUL_BITS  = (WORD_BITS > RHO_BITS) ? WORD_BITS : RHO_BITS;

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] Q_ONE =
    (FRAC_BITS < WORD_BITS - 1) ? WORD_BITS'(64'd1 << FRAC_BITS) : WMAX;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RHO      = 2'd0,
    CFG_USE_NUM  = 2'd1,
    CFG_NUM_LAM1 = 2'd2,
    CFG_NUM_LAM2 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] lam1;
    logic signed [WORD_BITS-1:0] lam2;
    logic signed [WORD_BITS-1:0] growth1;
    logic signed [WORD_BITS-1:0] growth2;
    logic signed [WORD_BITS-1:0] var1;
    logic signed [WORD_BITS-1:0] var2;
    logic signed [WORD_BITS-1:0] covar;
    logic                        last_point;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] exp_r1;
    logic signed [WORD_BITS-1:0] exp_r2;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Operand sources of the datapath
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_N1, SRC_N2, SRC_LAM1, SRC_LAM2, SRC_G1, SRC_G2, SRC_V1,
    SRC_V2, SRC_CV, SRC_PLAM1, SRC_PLAM2, SRC_PG1, SRC_PG2, SRC_PV1, SRC_PV2,
    SRC_PCV, SRC_RHO, SRC_SUM1, SRC_SUM2, SRC_MULQ, SRC_A1C, SRC_A2C, SRC_A1P,
    SRC_A2P, SRC_E1C, SRC_E2C, SRC_E1P, SRC_E2P, SRC_S, SRC_O1, SRC_O2
  } src_t;

  // Scratch registers
  typedef enum logic [3:0] {
    DST_A1C, DST_A2C, DST_A1P, DST_A2P, DST_E1C, DST_E2C, DST_E1P, DST_E2P,
    DST_S, DST_O1, DST_O2
  } dst_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic    alu_en;
    alu_op_t alu_op;
    src_t    alu_a;
    src_t    alu_b;
    dst_t    alu_dst;
    src_t    mul_a;
    src_t    mul_b;
    logic    wb_en;
    dst_t    wb_dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic commit;
    uop_t uop;
  } cmd_t;

  localparam uop_t UOP_NOP = '{
    alu_en:  1'b0,
    alu_op:  ALU_ADD,
    alu_a:   SRC_ZERO,
    alu_b:   SRC_ZERO,
    alu_dst: DST_A1C,
    mul_a:   SRC_ZERO,
    mul_b:   SRC_ZERO,
    wb_en:   1'b0,
    wb_dst:  DST_A1C
  };

  localparam int NSTEPS    = 23;
  localparam int STEP_BITS = $clog2(NSTEPS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NSTEPS - 1);

  function automatic uop_t set_alu(input uop_t u, input alu_op_t op, input src_t a,
                                   input src_t b, input dst_t d);
    uop_t r;
    r = u;
    r.alu_en  = 1'b1;
    r.alu_op  = op;
    r.alu_a   = a;
    r.alu_b   = b;
    r.alu_dst = d;
    return r;
  endfunction

  function automatic uop_t set_mul(input uop_t u, input src_t a, input src_t b);
    uop_t r;
    r = u;
    r.mul_a = a;
    r.mul_b = b;
    return r;
  endfunction

  function automatic uop_t set_wb(input uop_t u, input dst_t d);
    uop_t r;
    r = u;
    r.wb_en  = 1'b1;
    r.wb_dst = d;
    return r;
  endfunction

  // Schedule: x = sat(n - lam) * growth, t = x * var, b = x_other * covar,
  // E = sat(-t) - rho * b, for the current (C) and previous (P) point.
  function automatic uop_t ucode(input logic [STEP_BITS-1:0] step);
    uop_t u;
    u = UOP_NOP;
    case (step)
      0:  u = set_alu(UOP_NOP, ALU_SUB, SRC_N1, SRC_LAM1, DST_A1C);
      1:  u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_N2, SRC_LAM2, DST_A2C),
                      SRC_A1C, SRC_G1);
      2:  u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_N1, SRC_PLAM1, DST_A1P),
                      SRC_A2C, SRC_G2);
      3:  u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_N2, SRC_PLAM2, DST_A2P),
                      SRC_A1P, SRC_PG1);
      4:  u = set_wb(set_mul(UOP_NOP, SRC_A2P, SRC_PG2), DST_A1C);
      5:  u = set_wb(set_mul(UOP_NOP, SRC_A1C, SRC_V1), DST_A2C);
      6:  u = set_wb(set_mul(UOP_NOP, SRC_A1C, SRC_CV), DST_A1P);
      7:  u = set_wb(set_mul(UOP_NOP, SRC_A2C, SRC_V2), DST_A2P);
      8:  u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_ZERO, SRC_MULQ, DST_E1C),
                      SRC_A2C, SRC_CV);
      9:  u = set_mul(UOP_NOP, SRC_RHO, SRC_MULQ);
      10: u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_ZERO, SRC_MULQ, DST_E2C),
                      SRC_A1P, SRC_PV1);
      11: u = set_mul(UOP_NOP, SRC_RHO, SRC_MULQ);
      12: u = set_wb(set_mul(UOP_NOP, SRC_A1P, SRC_PCV), DST_S);
      13: u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_ZERO, SRC_MULQ, DST_E1P),
                      SRC_A2P, SRC_PV2);
      14: u = set_wb(set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_E2C, SRC_S, DST_E2C),
                             SRC_A2P, SRC_PCV), DST_S);
      15: u = set_mul(set_alu(UOP_NOP, ALU_SUB, SRC_E1C, SRC_S, DST_E1C),
                      SRC_RHO, SRC_MULQ);
      16: u = set_alu(UOP_NOP, ALU_SUB, SRC_ZERO, SRC_MULQ, DST_E2P);
      17: u = set_mul(set_alu(UOP_NOP, ALU_ADD, SRC_SUM1, SRC_E1C, DST_O1),
                      SRC_RHO, SRC_MULQ);
      18: u = set_alu(UOP_NOP, ALU_SUB, SRC_E2P, SRC_MULQ, DST_E2P);
      19: u = set_alu(UOP_NOP, ALU_ADD, SRC_SUM2, SRC_E2C, DST_O2);
      20: u = set_alu(UOP_NOP, ALU_SUB, SRC_E1P, SRC_MULQ, DST_E1P);
      21: u = set_alu(UOP_NOP, ALU_SUB, SRC_O1, SRC_E1P, DST_O1);
      22: u = set_alu(UOP_NOP, ALU_SUB, SRC_O2, SRC_E2P, DST_O2);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

endpackage

FILE: sv/ert_ifs.sv
`timescale 1ns / 1ps

interface ert_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ert_pkg::WORD_BITS-1:0] lam1;
  logic signed [ert_pkg::WORD_BITS-1:0] lam2;
  logic signed [ert_pkg::WORD_BITS-1:0] growth1;
  logic signed [ert_pkg::WORD_BITS-1:0] growth2;
  logic signed [ert_pkg::WORD_BITS-1:0] var1;
  logic signed [ert_pkg::WORD_BITS-1:0] var2;
  logic signed [ert_pkg::WORD_BITS-1:0] covar;
  logic                                 last_point;

  modport source (output valid, lam1, lam2, growth1, growth2, var1, var2, covar,
                  last_point, input ready);
  modport sink (input valid, lam1, lam2, growth1, growth2, var1, var2, covar,
                last_point, output ready);
endinterface

interface ert_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ert_pkg::WORD_BITS-1:0] exp_r1;
  logic signed [ert_pkg::WORD_BITS-1:0] exp_r2;

  modport source (output valid, exp_r1, exp_r2, input ready);
  modport sink (input valid, exp_r1, exp_r2, output ready);
endinterface

FILE: sv/ert_mul.sv
`timescale 1ns / 1ps

// Three-stage signed fractional multiplier: partial products, sum with
// rounding half, then shift and saturate. Magnitude form gives ties away
// from zero.
module ert_mul (
  input  logic                                 clk,
  input  logic signed [ert_pkg::MUL_BITS-1:0]  a,
  input  logic signed [ert_pkg::MUL_BITS-1:0]  b,
  output logic signed [ert_pkg::WORD_BITS-1:0] q
);

  localparam int MW  = ert_pkg::MUL_BITS;
  localparam int W   = ert_pkg::WORD_BITS;
  localparam int F   = ert_pkg::FRAC_BITS;
  localparam int HW  = (MW + 1) / 2;
  localparam int HW2 = 2 * HW;
  localparam int PW  = 4 * HW;
  localparam int MSW = PW - F;

  localparam logic [PW-1:0]  HALF    = PW'(1) << (F - 1);
  localparam logic [MSW-1:0] LIM_POS = MSW'(ert_pkg::WMAX);
  localparam logic [MSW-1:0] LIM_NEG = LIM_POS + 1'b1;

  logic [MW-1:0]  ma, mb;
  logic [HW2-1:0] ma_w, mb_w;
  logic [HW-1:0]  al, ah, bl, bh;

  logic [HW2-1:0] p00_r, p01_r, p10_r, p11_r;
  logic           neg1_r;
  logic [PW-1:0]  sum_r;
  logic           neg2_r;
  logic signed [W-1:0] q_r;

  logic [MSW-1:0] m;
  logic [W-1:0]   mw;
  logic           sat;

  assign ma   = a[MW-1] ? (~a + 1'b1) : a;
  assign mb   = b[MW-1] ? (~b + 1'b1) : b;
  assign ma_w = HW2'(ma);
  assign mb_w = HW2'(mb);
  assign al   = ma_w[HW-1:0];
  assign ah   = ma_w[HW2-1:HW];
  assign bl   = mb_w[HW-1:0];
  assign bh   = mb_w[HW2-1:HW];

  always_ff @(posedge clk) begin
    p00_r  <= HW2'(al) * HW2'(bl);
    p01_r  <= HW2'(al) * HW2'(bh);
    p10_r  <= HW2'(ah) * HW2'(bl);
    p11_r  <= HW2'(ah) * HW2'(bh);
    neg1_r <= a[MW-1] ^ b[MW-1];
  end

  always_ff @(posedge clk) begin
    sum_r  <= PW'(p00_r) + (PW'(p01_r) << HW) + (PW'(p10_r) << HW)
              + (PW'(p11_r) << HW2) + HALF;
    neg2_r <= neg1_r;
  end

  assign m   = sum_r[PW-1:F];
  assign mw  = m[W-1:0];
  assign sat = m > (neg2_r ? LIM_NEG : LIM_POS);

  always_ff @(posedge clk) begin
    if (sat) begin
      q_r <= neg2_r ? ert_pkg::WMIN : ert_pkg::WMAX;
    end else if (neg2_r) begin
      q_r <= $signed(~mw + 1'b1);
    end else begin
      q_r <= $signed(mw);
    end
  end

  assign q = q_r;

endmodule

FILE: sv/ert_ctrl.sv
`timescale 1ns / 1ps

module ert_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ert_pkg::cmd_t cmd
);

  ert_pkg::state_t state_r, state_nxt;
  logic [ert_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ert_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.uop   = ert_pkg::UOP_NOP;
    case (state_r)
      ert_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ert_pkg::ST_RUN;
        end
      end
      ert_pkg::ST_RUN: begin
        cmd.uop = ert_pkg::ucode(step_r);
        if (step_r == ert_pkg::LAST_STEP) begin
          state_nxt = ert_pkg::ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ert_pkg::ST_DONE: begin
        // result moves to the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ert_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ert_pkg::ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/ert_dp.sv
`timescale 1ns / 1ps

module ert_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ert_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [ert_pkg::MUL_BITS-1:0]        cfg_data,
  input  ert_pkg::item_t                      item_i,
  input  ert_pkg::cmd_t                       cmd,
  output ert_pkg::res_t                       res_o
);

  localparam int W  = ert_pkg::WORD_BITS;
  localparam int MW = ert_pkg::MUL_BITS;
  localparam int WX = W + 1;

  // configuration
  logic signed [ert_pkg::RHO_BITS-1:0] rho_r;
  logic                                use_num_r;
  logic signed [W-1:0]                 nlam1_r, nlam2_r;

  // latched item
  logic signed [W-1:0] lam1_r, lam2_r, g1_r, g2_r, v1_r, v2_r, cv_r;
  logic                last_r;

  // previous point and running sums
  logic signed [W-1:0] plam1_r, plam2_r, pg1_r, pg2_r, pv1_r, pv2_r, pcv_r;
  logic signed [W-1:0] sum1_r, sum2_r;

  // scratch
  logic signed [W-1:0] a1c_r, a2c_r, a1p_r, a2p_r;
  logic signed [W-1:0] e1c_r, e2c_r, e1p_r, e2p_r, s_r, o1_r, o2_r;

  logic signed [W-1:0] res1_r, res2_r;

  logic signed [W-1:0]  n1, n2, mul_q;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [W-1:0]  alu_a, alu_b, alu_q;
  logic signed [WX-1:0] alu_sum;

  assign n1 = use_num_r ? nlam1_r : lam1_r;
  assign n2 = use_num_r ? nlam2_r : lam2_r;

  function automatic logic signed [MW-1:0] pick(input ert_pkg::src_t s);
    logic signed [W-1:0] v;
    v = '0;
    case (s)
      ert_pkg::SRC_ZERO:  v = '0;
      ert_pkg::SRC_N1:    v = n1;
      ert_pkg::SRC_N2:    v = n2;
      ert_pkg::SRC_LAM1:  v = lam1_r;
      ert_pkg::SRC_LAM2:  v = lam2_r;
      ert_pkg::SRC_G1:    v = g1_r;
      ert_pkg::SRC_G2:    v = g2_r;
      ert_pkg::SRC_V1:    v = v1_r;
      ert_pkg::SRC_V2:    v = v2_r;
      ert_pkg::SRC_CV:    v = cv_r;
      ert_pkg::SRC_PLAM1: v = plam1_r;
      ert_pkg::SRC_PLAM2: v = plam2_r;
      ert_pkg::SRC_PG1:   v = pg1_r;
      ert_pkg::SRC_PG2:   v = pg2_r;
      ert_pkg::SRC_PV1:   v = pv1_r;
      ert_pkg::SRC_PV2:   v = pv2_r;
      ert_pkg::SRC_PCV:   v = pcv_r;
      ert_pkg::SRC_SUM1:  v = sum1_r;
      ert_pkg::SRC_SUM2:  v = sum2_r;
      ert_pkg::SRC_MULQ:  v = mul_q;
      ert_pkg::SRC_A1C:   v = a1c_r;
      ert_pkg::SRC_A2C:   v = a2c_r;
      ert_pkg::SRC_A1P:   v = a1p_r;
      ert_pkg::SRC_A2P:   v = a2p_r;
      ert_pkg::SRC_E1C:   v = e1c_r;
      ert_pkg::SRC_E2C:   v = e2c_r;
      ert_pkg::SRC_E1P:   v = e1p_r;
      ert_pkg::SRC_E2P:   v = e2p_r;
      ert_pkg::SRC_S:     v = s_r;
      ert_pkg::SRC_O1:    v = o1_r;
      ert_pkg::SRC_O2:    v = o2_r;
      default:            v = '0;
    endcase
    // rho is the one operand that may be wider than a word
    if (s == ert_pkg::SRC_RHO) begin
      return MW'(rho_r);
    end
    return MW'(v);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_r     <= '0;
      use_num_r <= 1'b0;
      nlam1_r   <= '0;
      nlam2_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ert_pkg::CFG_RHO:      rho_r     <= cfg_data[ert_pkg::RHO_BITS-1:0];
        ert_pkg::CFG_USE_NUM:  use_num_r <= cfg_data[0];
        ert_pkg::CFG_NUM_LAM1: nlam1_r   <= cfg_data[W-1:0];
        ert_pkg::CFG_NUM_LAM2: nlam2_r   <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lam1_r <= item_i.lam1;
      lam2_r <= item_i.lam2;
      g1_r   <= item_i.growth1;
      g2_r   <= item_i.growth2;
      v1_r   <= item_i.var1;
      v2_r   <= item_i.var2;
      cv_r   <= item_i.covar;
      last_r <= item_i.last_point;
    end
  end

  ert_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  // operand muxes follow every register the selector can reach
  always_comb begin
    mul_a = pick(cmd.uop.mul_a);
    mul_b = pick(cmd.uop.mul_b);
  end

  // saturating add / subtract
  always_comb begin
    alu_a = W'(pick(cmd.uop.alu_a));
    alu_b = W'(pick(cmd.uop.alu_b));
    if (cmd.uop.alu_op == ert_pkg::ALU_SUB) begin
      alu_sum = WX'(alu_a) - WX'(alu_b);
    end else begin
      alu_sum = WX'(alu_a) + WX'(alu_b);
    end
    if (alu_sum[W] != alu_sum[W-1]) begin
      alu_q = alu_sum[W] ? ert_pkg::WMIN : ert_pkg::WMAX;
    end else begin
      alu_q = alu_sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uop.alu_en) begin
      case (cmd.uop.alu_dst)
        ert_pkg::DST_A1C: a1c_r <= alu_q;
        ert_pkg::DST_A2C: a2c_r <= alu_q;
        ert_pkg::DST_A1P: a1p_r <= alu_q;
        ert_pkg::DST_A2P: a2p_r <= alu_q;
        ert_pkg::DST_E1C: e1c_r <= alu_q;
        ert_pkg::DST_E2C: e2c_r <= alu_q;
        ert_pkg::DST_E1P: e1p_r <= alu_q;
        ert_pkg::DST_E2P: e2p_r <= alu_q;
        ert_pkg::DST_S:   s_r   <= alu_q;
        ert_pkg::DST_O1:  o1_r  <= alu_q;
        ert_pkg::DST_O2:  o2_r  <= alu_q;
        default: ;
      endcase
    end
    if (cmd.uop.wb_en) begin
      case (cmd.uop.wb_dst)
        ert_pkg::DST_A1C: a1c_r <= mul_q;
        ert_pkg::DST_A2C: a2c_r <= mul_q;
        ert_pkg::DST_A1P: a1p_r <= mul_q;
        ert_pkg::DST_A2P: a2p_r <= mul_q;
        ert_pkg::DST_E1C: e1c_r <= mul_q;
        ert_pkg::DST_E2C: e2c_r <= mul_q;
        ert_pkg::DST_E1P: e1p_r <= mul_q;
        ert_pkg::DST_E2P: e2p_r <= mul_q;
        ert_pkg::DST_S:   s_r   <= mul_q;
        ert_pkg::DST_O1:  o1_r  <= mul_q;
        ert_pkg::DST_O2:  o2_r  <= mul_q;
        default: ;
      endcase
    end
  end

  // recurrence state; a last item sends it back to today
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.commit && last_r)) begin
      plam1_r <= '0;
      plam2_r <= '0;
      pg1_r   <= ert_pkg::Q_ONE;
      pg2_r   <= ert_pkg::Q_ONE;
      pv1_r   <= '0;
      pv2_r   <= '0;
      pcv_r   <= '0;
      sum1_r  <= '0;
      sum2_r  <= '0;
    end else if (cmd.commit) begin
      plam1_r <= lam1_r;
      plam2_r <= lam2_r;
      pg1_r   <= g1_r;
      pg2_r   <= g2_r;
      pv1_r   <= v1_r;
      pv2_r   <= v2_r;
      pcv_r   <= cv_r;
      sum1_r  <= o1_r;
      sum2_r  <= o2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res1_r <= o1_r;
      res2_r <= o2_r;
    end
  end

  assign res_o.exp_r1 = res1_r;
  assign res_o.exp_r2 = res2_r;

endmodule

FILE: sv/expected_rate_recurrence.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_item   in   valid/ready    lam1 lam2 growth1 growth2 var1 var2 covar last_point
// out_item  out  valid/ready    exp_r1 exp_r2
// cfg_*     in   cfg_we         cfg_idx selects rho, use_numeraire, numeraire_lam1/2
//
// An item passes from acceptance to the next acceptance through the idle
// state that takes it, 23 microcode steps that share one 3-stage multiplier over
// 16 products, and a done state that moves the result into the output register.
// The output register parts the sides: a waiting result does not stall the
// next item unless a second result is ready before the first is taken.
// Synchronous active-low reset returns the recurrence to today and clears
// the configuration; there is no clearing pass.
module expected_rate_recurrence (
  input  logic                             clk,
  input  logic                             rst_n,
  ert_in_if.sink                           in_item,
  ert_out_if.source                        out_item,
  input  logic                             cfg_we,
  input  logic [ert_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [ert_pkg::MUL_BITS-1:0]     cfg_data
);

  ert_pkg::item_t item;
  ert_pkg::res_t  res;
  ert_pkg::cmd_t  cmd;

  assign item.lam1       = in_item.lam1;
  assign item.lam2       = in_item.lam2;
  assign item.growth1    = in_item.growth1;
  assign item.growth2    = in_item.growth2;
  assign item.var1       = in_item.var1;
  assign item.var2       = in_item.var2;
  assign item.covar      = in_item.covar;
  assign item.last_point = in_item.last_point;

  ert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd)
  );

  ert_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item_i   (item),
    .cmd      (cmd),
    .res_o    (res)
  );

  assign out_item.exp_r1 = res.exp_r1;
  assign out_item.exp_r2 = res.exp_r2;

`ifndef SYNTHESIS
  // an accepted item keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("input ready right after an accepted item");

  // a result never overwrites one that is still waiting
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_item.valid || out_item.ready))
    else $error("result committed over a pending output");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_item.valid)
    else $error("committed result not presented");

  // loads and commits happen only with the schedule idle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load || cmd.commit) |-> (!cmd.uop.alu_en && !cmd.uop.wb_en))
    else $error("load or commit during microcode step");
`endif

endmodule

FILE: tb/sv/tb_expected_rate_recurrence.sv
`timescale 1ns / 1ps

module tb_expected_rate_recurrence;
  import ert_pkg::*;

  localparam longint WMAX_L  = WMAX;
  localparam longint WMIN_L  = WMIN;
  localparam longint Q_ONE_L = Q_ONE;
  localparam longint RHO_MAX = (longint'(1) <<< (RHO_BITS - 1)) - 1;
  localparam longint RHO_MIN = -(longint'(1) <<< (RHO_BITS - 1));

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [MUL_BITS-1:0] cfg_data;

  ert_in_if  in_item ();
  ert_out_if out_item ();

  expected_rate_recurrence uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Register copies and recurrence state of the predictor
  longint rho_cfg, nlam1_cfg, nlam2_cfg;
  bit     use_num_cfg;
  item_t  last_pt;
  longint acc1, acc2;

  item_t point_q[$];
  res_t  want_rates[$];
  item_t cur;
  int    queued, sent, checked, errors, lasts, settings;
  int    gap, stall;
  bit    tx_busy_mode, rx_busy_mode;
  logic  drv_valid, mon_ready;

  function automatic longint clampw(longint v);
    if (v > WMAX_L) return WMAX_L;
    if (v < WMIN_L) return WMIN_L;
    return v;
  endfunction

  function automatic longint ssub(longint a, longint b);
    return clampw(a - b);
  endfunction

  // Exact product, round half away from zero on the magnitude, saturate
  function automatic longint qmul(longint x, longint y);
    logic [127:0] p, m;
    bit neg;
    neg = (x < 0) != (y < 0);
    p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
    m = (p + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) return (m > 128'(WMAX_L) + 128'(1)) ? WMIN_L : -longint'(m);
    return (m > 128'(WMAX_L)) ? WMAX_L : longint'(m);
  endfunction

  function automatic longint rate_term(longint lk, longint nk, longint lo, longint no,
                                       longint gk, longint go, longint vk, longint cv);
    longint t1, b;
    t1 = qmul(qmul(ssub(nk, lk), gk), vk);
    b  = qmul(qmul(ssub(no, lo), go), cv);
    return ssub(clampw(-t1), qmul(rho_cfg, b));
  endfunction

  function automatic void reset_curve();
    last_pt = '0;
    last_pt.growth1 = Q_ONE;
    last_pt.growth2 = Q_ONE;
    acc1 = 0;
    acc2 = 0;
  endfunction

  function automatic res_t advance_rates(item_t p);
    longint l1, l2, n1, n2, e1p, e2p, e1c, e2c, o1, o2;
    res_t r;
    l1 = p.lam1;
    l2 = p.lam2;
    n1 = use_num_cfg ? nlam1_cfg : l1;
    n2 = use_num_cfg ? nlam2_cfg : l2;
    e1p = rate_term(last_pt.lam1, n1, last_pt.lam2, n2, last_pt.growth1, last_pt.growth2,
                    last_pt.var1, last_pt.covar);
    e2p = rate_term(last_pt.lam2, n2, last_pt.lam1, n1, last_pt.growth2, last_pt.growth1,
                    last_pt.var2, last_pt.covar);
    e1c = rate_term(l1, n1, l2, n2, p.growth1, p.growth2, p.var1, p.covar);
    e2c = rate_term(l2, n2, l1, n1, p.growth2, p.growth1, p.var2, p.covar);
    o1 = ssub(clampw(acc1 + e1c), e1p);
    o2 = ssub(clampw(acc2 + e2c), e2p);
    r.exp_r1 = o1[WORD_BITS-1:0];
    r.exp_r2 = o2[WORD_BITS-1:0];
    if (p.last_point) begin
      reset_curve();
    end else begin
      last_pt = p;
      acc1 = o1;
      acc2 = o2;
    end
    return r;
  endfunction

  function automatic longint qm(int milli);
    return (longint'(milli) <<< FRAC_BITS) / 1000;
  endfunction

  function automatic longint rand_word();
    longint r;
    int k;
    r = {$urandom, $urandom};
    k = $urandom_range(0, 99);
    if (k < 55) return r >>> 28;  // about +-8.0
    if (k < 85) return longint'($signed(r[WORD_BITS-1:0]));
    case ($urandom_range(0, 6))
      0: return WMAX_L;
      1: return WMIN_L;
      2: return 0;
      3: return Q_ONE_L;
      4: return -Q_ONE_L;
      5: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic item_t make_pt(longint l1, longint l2, longint g1, longint g2,
                                    longint v1, longint v2, longint cv, bit last);
    item_t p;
    p.lam1 = l1[WORD_BITS-1:0];
    p.lam2 = l2[WORD_BITS-1:0];
    p.growth1 = g1[WORD_BITS-1:0];
    p.growth2 = g2[WORD_BITS-1:0];
    p.var1 = v1[WORD_BITS-1:0];
    p.var2 = v2[WORD_BITS-1:0];
    p.covar = cv[WORD_BITS-1:0];
    p.last_point = last;
    return p;
  endfunction

  function automatic void push_point(item_t p);
    point_q.push_back(p);
    queued++;
    if (p.last_point) lasts++;
  endfunction

  function automatic void queue_directed();
    push_point(make_pt(0, 0, 0, 0, 0, 0, 0, 1'b0));
    push_point(make_pt(qm(500), qm(300), qm(1100), qm(900), qm(20), qm(30), qm(10), 1'b0));
    push_point(make_pt(qm(1000), qm(700), qm(1300), qm(800), qm(40), qm(50), qm(-20), 1'b0));
    push_point(make_pt(WMAX_L, WMAX_L, WMAX_L, WMAX_L, WMAX_L, WMAX_L, WMAX_L, 1'b0));
    push_point(make_pt(WMIN_L, WMIN_L, WMIN_L, WMIN_L, WMIN_L, WMIN_L, WMIN_L, 1'b0));
    push_point(make_pt(WMIN_L, WMAX_L, WMAX_L, WMIN_L, WMAX_L, WMIN_L, WMIN_L, 1'b0));
    // one-LSB differences against factors of one half: rounding ties both signs
    push_point(make_pt(qm(3000) - 1, qm(-2000) + 1, longint'(1) <<< 31, longint'(1) <<< 31,
                       longint'(1) <<< 31, -(longint'(1) <<< 31), -(longint'(1) <<< 31),
                       1'b0));
    push_point(make_pt(qm(1500), qm(900), qm(1400), qm(700), qm(60), qm(70), qm(30), 1'b1));
    push_point(make_pt(qm(400), qm(200), qm(1050), qm(950), qm(10), qm(15), qm(5), 1'b0));
    push_point(make_pt(qm(800), qm(600), qm(1200), qm(850), qm(25), qm(35), qm(-15), 1'b1));
    push_point(make_pt(qm(-700), qm(250), qm(-900), qm(1600), qm(-80), qm(90), qm(45), 1'b1));
    push_point(make_pt(WMAX_L, WMIN_L, 1, -1, WMAX_L, WMIN_L, WMAX_L, 1'b0));
  endfunction

  // One maturity curve; returns the number of items queued
  function automatic int queue_curve();
    int len, kind, i;
    longint la1, la2;
    item_t p;
    len = $urandom_range(1, 20);
    kind = $urandom_range(0, 9);
    la1 = 0;
    la2 = 0;
    for (i = 0; i < len; i++) begin
      if (kind < 6) begin
        la1 += longint'($urandom_range(0, 32'h8000_0000));
        la2 += longint'($urandom_range(0, 32'h8000_0000));
        p = make_pt(la1, la2,
                    Q_ONE_L + longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000,
                    Q_ONE_L + longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000,
                    longint'($urandom_range(0, 32'h1000_0000)),
                    longint'($urandom_range(0, 32'h1000_0000)),
                    longint'($urandom_range(0, 32'h1000_0000)) - 64'sh0800_0000,
                    i == len - 1);
      end else begin
        p = make_pt(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(),
                    (kind == 9) ? ($urandom_range(0, 3) == 0) : (i == len - 1));
      end
      push_point(p);
    end
    return len;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [MUL_BITS-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_RHO:      rho_cfg = longint'($signed(data[RHO_BITS-1:0]));
      CFG_USE_NUM:  use_num_cfg = data[0];
      CFG_NUM_LAM1: nlam1_cfg = longint'($signed(data[WORD_BITS-1:0]));
      CFG_NUM_LAM2: nlam2_cfg = longint'($signed(data[WORD_BITS-1:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input longint rho_v, input bit use_v, input longint n1,
                          input longint n2);
    logic [MUL_BITS-1:0] d;
    // unused upper bits carry noise; only the low bits of rho and the flag count
    d = MUL_BITS'({$urandom, $urandom});
    d[RHO_BITS-1:0] = rho_v[RHO_BITS-1:0];
    write_reg(CFG_RHO, d);
    d = MUL_BITS'({$urandom, $urandom});
    d[0] = use_v;
    write_reg(CFG_USE_NUM, d);
    write_reg(CFG_NUM_LAM1, n1[MUL_BITS-1:0]);
    write_reg(CFG_NUM_LAM2, n2[MUL_BITS-1:0]);
    settings++;
  endtask

  task automatic random_regs();
    longint r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: r = RHO_MAX;
      1: r = RHO_MIN;
      2: r = longint'($signed(r[RHO_BITS-1:0]));
      default: r = longint'($urandom) * 2 - (longint'(1) <<< 32);  // within +-1
    endcase
    set_regs(r, 1'($urandom_range(0, 1)), rand_word(), rand_word());
  endtask

  task automatic settle();
    while (sent != queued || want_rates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver: the pause after an accepted item counts down only while the block shows ready
  always @(posedge clk) begin
    if (!rst_n) begin
      in_item.valid <= 1'b0;
      gap = 0;
    end else begin
      drv_valid = in_item.valid;
      if (in_item.valid && in_item.ready) begin
        want_rates.push_back(advance_rates(cur));
        sent++;
        if ($urandom_range(0, 63) == 0) tx_busy_mode = !tx_busy_mode;
        gap = tx_busy_mode ? 0 : $urandom_range(0, 3);
        drv_valid = 1'b0;
      end else if (!drv_valid && gap > 0 && in_item.ready) begin
        gap--;
      end
      if (!drv_valid && gap == 0 && point_q.size() > 0) begin
        cur = point_q.pop_front();
        in_item.lam1       <= cur.lam1;
        in_item.lam2       <= cur.lam2;
        in_item.growth1    <= cur.growth1;
        in_item.growth2    <= cur.growth2;
        in_item.var1       <= cur.var1;
        in_item.var2       <= cur.var2;
        in_item.covar      <= cur.covar;
        in_item.last_point <= cur.last_point;
        drv_valid = 1'b1;
      end
      in_item.valid <= drv_valid;
    end
  end

  // Monitor: the stall after a taken result counts down only while a result is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      stall = 0;
    end else begin
      mon_ready = out_item.ready;
      if (out_item.valid && out_item.ready) begin
        if (want_rates.size() == 0) begin
          $error("exp_r1/exp_r2: result with no item outstanding, got %0d / %0d",
                 out_item.exp_r1, out_item.exp_r2);
          errors++;
        end else begin
          checked++;
          if (out_item.exp_r1 !== want_rates[0].exp_r1) begin
            $error("exp_r1: expected %0d, got %0d", want_rates[0].exp_r1, out_item.exp_r1);
            errors++;
          end
          if (out_item.exp_r2 !== want_rates[0].exp_r2) begin
            $error("exp_r2: expected %0d, got %0d", want_rates[0].exp_r2, out_item.exp_r2);
            errors++;
          end
          void'(want_rates.pop_front());
        end
        if ($urandom_range(0, 63) == 0) rx_busy_mode = !rx_busy_mode;
        stall = rx_busy_mode ? 0 : $urandom_range(0, 3);
        mon_ready = (stall == 0);
      end else if (!out_item.ready) begin
        if (out_item.valid && stall > 0) stall--;
        mon_ready = (stall == 0);
      end
      out_item.ready <= mon_ready;
    end
  end

  initial begin
    int ph, n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_RHO;
    cfg_data = '0;
    in_item.valid = 1'b0;
    in_item.lam1 = '0;
    in_item.lam2 = '0;
    in_item.growth1 = '0;
    in_item.growth2 = '0;
    in_item.var1 = '0;
    in_item.var2 = '0;
    in_item.covar = '0;
    in_item.last_point = 1'b0;
    out_item.ready = 1'b0;
    rho_cfg = 0;
    use_num_cfg = 1'b0;
    nlam1_cfg = 0;
    nlam2_cfg = 0;
    reset_curve();
    queued = 0; sent = 0; checked = 0; errors = 0; lasts = 0; settings = 0;
    tx_busy_mode = 1'b0;
    rx_busy_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(longint'(1) <<< 31, 1'b1, qm(3000), qm(-2000));
    queue_directed();
    settle();
    set_regs(RHO_MAX, 1'b0, WMAX_L, WMIN_L);
    queue_directed();
    settle();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_regs(RHO_MIN, 1'b1, WMIN_L, WMAX_L);
        1: set_regs(Q_ONE_L, 1'b1, rand_word(), rand_word());
        2: set_regs(-Q_ONE_L, 1'b0, 0, 0);
        default: random_regs();
      endcase
      n = 0;
      while (n < 150) n += queue_curve();
      settle();
    end

    repeat (30) @(posedge clk);
    $display("Run covered %0d items under %0d register settings, %0d of them last points.",
             sent, settings, lasts);
    $display("%0d results compared, %0d mismatches.", checked, errors);
    if (errors == 0 && want_rates.size() == 0) begin
      $display("tb_expected_rate_recurrence: PASS");
    end else begin
      $display("tb_expected_rate_recurrence: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_expected_rate_recurrence: FAIL");
    $finish;
  end

endmodule
